// ===== design/mfmse_pkg.sv =====
// package for the mfm sector encoder: item types, op codes, sequence constants
// and the crc-16-ccitt and mfm cell functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mfmse_pkg;

    // input item op codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // format bytes
    localparam logic [7:0] MARK_BYTE = 8'hA1;
    localparam logic [7:0] IDAM_BYTE = 8'hFE;
    localparam logic [7:0] DAM_BYTE  = 8'hFB;
    localparam logic [7:0] GAP_BYTE  = 8'h4E;
    localparam logic [7:0] SIZE_CODE = 8'h02;
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // result word sequencing
    localparam int IDX_W = 6;
    localparam logic [IDX_W-1:0] START_LAST  = IDX_W'(29);
    localparam logic [IDX_W-1:0] FINISH_LAST = IDX_W'(55);

    // default depth of the job queue between front and back
    localparam int JOB_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  track;
        logic [3:0]  sector;
        logic [15:0] data_pair;
    } in_item_t;

    typedef struct packed {
        logic [31:0] cells;
        logic [1:0]  cells_valid;
        logic        last;
    } out_item_t;

    // classified job, header bytes already formed
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cyl;
        logic [7:0]  head;
        logic [7:0]  rec;
        logic [15:0] data;
    } job_t;

    // crc-16-ccitt over two bytes, msb first, first byte in the upper half
    function automatic logic [15:0] crc16_pair(input logic [15:0] crc_in,
                                               input logic [15:0] pair);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 15; i >= 0; i--) begin
            fb = c[15] ^ pair[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // mfm cell of one byte, clock bit first; a mark byte loses clock bit 5
    function automatic logic [15:0] mfm_cell(input logic [7:0] b,
                                             input logic       prev,
                                             input logic       mark);
        logic [15:0] c;
        logic        p;
        c = '0;
        p = prev;
        for (int i = 7; i >= 0; i--) begin
            c[2*i+1] = ~(p | b[i]);
            c[2*i]   = b[i];
            p        = b[i];
        end
        if (mark)
            c[5] = 1'b0;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/mfmse_front.sv =====
// front part: accepts input items, forms header bytes and queues jobs
// depends on mfmse_pkg
`timescale 1ns / 1ps
`default_nettype none

module mfmse_front
    import mfmse_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          job_valid,
    output job_t          job,
    input  wire logic     job_pop
);

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(JOB_DEPTH);

    job_t             slot_reg [JOB_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    job_t             job_new;
    logic             wr_en;
    logic             rd_en;

    // classify the item and form the header bytes
    always_comb
    begin
        job_new.op   = item.op;
        job_new.cyl  = {1'b0, item.track[7:1]};
        job_new.head = {7'd0, item.track[0]};
        job_new.rec  = {4'd0, item.sector} + 8'd1;
        job_new.data = item.data_pair;
    end

    // unused op code is taken and dropped
    assign full      = (cnt_reg == DEPTH_CNT);
    assign wr_en     = push && !full && (item.op != OP_UNUSED);
    assign job_valid = (cnt_reg != '0);
    assign rd_en     = job_pop && job_valid;
    assign job       = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // job slots
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= job_new;
    end

endmodule

`default_nettype wire

// ===== design/mfmse_back.sv =====
// back part: steps through each job's bytes, one result word a cycle
// unless res_full, keeps the crc and the last data bit; depends on mfmse_pkg
`timescale 1ns / 1ps
`default_nettype none

module mfmse_back
    import mfmse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_pop,
    input  wire logic res_full,
    output logic      res_wr,
    output out_item_t res
);

    logic             busy_reg, busy_next;
    job_t             job_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]      hcrc_reg;
    logic [15:0]      crc_reg, crc_next;
    logic             prev_reg, prev_next;

    logic [IDX_W-1:0] last_idx;
    logic             advance;
    logic             done;
    logic             load;
    logic [7:0]       b0, b1;
    logic             mk0, mk1;
    logic             two;
    logic             fin;
    logic [15:0]      crc_base;
    logic [15:0]      crc_calc;
    logic             hcrc_upd;
    logic             crc_upd;
    logic             crc_clr;
    logic [15:0]      cell_hi, cell_lo;

    // last word index of the current job
    always_comb
    begin
        unique case (job_reg.op)
            OP_START:  last_idx = START_LAST;
            OP_FINISH: last_idx = FINISH_LAST;
            default:   last_idx = '0;
        endcase
    end

    assign advance = busy_reg && !res_full;
    assign done    = advance && (idx_reg == last_idx);
    assign load    = (!busy_reg || done) && job_valid;
    assign job_pop = load;

    // byte pair and crc work for the current word
    always_comb
    begin
        b0       = 8'h00;
        b1       = 8'h00;
        mk0      = 1'b0;
        mk1      = 1'b0;
        two      = 1'b1;
        fin      = 1'b0;
        crc_base = crc_reg;
        hcrc_upd = 1'b0;
        crc_upd  = 1'b0;
        crc_clr  = 1'b0;
        unique case (job_reg.op)
            OP_START:
            begin
                if (idx_reg == IDX_W'(6))
                begin
                    b0 = MARK_BYTE; b1 = MARK_BYTE; mk0 = 1'b1; mk1 = 1'b1;
                    crc_base = CRC_PRESET; hcrc_upd = 1'b1;
                end
                else if (idx_reg == IDX_W'(7))
                begin
                    b0 = MARK_BYTE; b1 = IDAM_BYTE; mk0 = 1'b1;
                    crc_base = hcrc_reg; hcrc_upd = 1'b1;
                end
                else if (idx_reg == IDX_W'(8))
                begin
                    b0 = job_reg.cyl; b1 = job_reg.head;
                    crc_base = hcrc_reg; hcrc_upd = 1'b1;
                end
                else if (idx_reg == IDX_W'(9))
                begin
                    b0 = job_reg.rec; b1 = SIZE_CODE;
                    crc_base = hcrc_reg; hcrc_upd = 1'b1;
                end
                else if (idx_reg == IDX_W'(10))
                begin
                    b0 = hcrc_reg[15:8]; b1 = hcrc_reg[7:0];
                end
                else if (idx_reg >= IDX_W'(11) && idx_reg <= IDX_W'(21))
                begin
                    b0 = GAP_BYTE; b1 = GAP_BYTE;
                end
                else if (idx_reg == IDX_W'(28))
                begin
                    b0 = MARK_BYTE; b1 = MARK_BYTE; mk0 = 1'b1; mk1 = 1'b1;
                    crc_base = CRC_PRESET; crc_upd = 1'b1;
                end
                else if (idx_reg == IDX_W'(29))
                begin
                    b0 = MARK_BYTE; b1 = DAM_BYTE; mk0 = 1'b1;
                    crc_upd = 1'b1;
                end
            end
            OP_DATA:
            begin
                b0 = job_reg.data[15:8];
                b1 = job_reg.data[7:0];
                crc_upd = 1'b1;
            end
            OP_FINISH:
            begin
                if (idx_reg == '0)
                begin
                    b0 = crc_reg[15:8]; b1 = crc_reg[7:0];
                    crc_clr = 1'b1;
                end
                else if (idx_reg == FINISH_LAST)
                begin
                    b0 = GAP_BYTE; two = 1'b0; fin = 1'b1;
                end
                else
                begin
                    b0 = GAP_BYTE; b1 = GAP_BYTE;
                end
            end
            default:
            begin
                two = 1'b1;
            end
        endcase
    end

    assign crc_calc = crc16_pair(crc_base, {b0, b1});

    // mfm cells, the second cell chains on the first byte's last bit
    assign cell_hi = mfm_cell(b0, prev_reg, mk0);
    assign cell_lo = two ? mfm_cell(b1, b0[0], mk1) : 16'h0000;

    assign res_wr            = advance;
    assign res.cells         = {cell_hi, cell_lo};
    assign res.cells_valid   = two ? 2'd2 : 2'd1;
    assign res.last          = fin;

    // sequencer and state updates
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        prev_next = prev_reg;
        if (advance)
        begin
            idx_next  = idx_reg + 1'b1;
            prev_next = two ? b1[0] : b0[0];
            if (crc_upd)
                crc_next = crc_calc;
            else if (crc_clr)
                crc_next = CRC_PRESET;
        end
        if (done)
            busy_next = 1'b0;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            crc_reg  <= CRC_PRESET;
            prev_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            crc_reg  <= crc_next;
            prev_reg <= prev_next;
        end
    end

    // job and header crc hold no reset
    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= job;
        if (advance && hcrc_upd)
            hcrc_reg <= crc_calc;
    end

endmodule

`default_nettype wire

// ===== design/mfmse_outq.sv =====
// two-entry result queue between the back part and the result port
// depends on mfmse_pkg
`timescale 1ns / 1ps
`default_nettype none

module mfmse_outq
    import mfmse_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire out_item_t wdata,
    output logic           qfull,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    out_item_t  ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_en;

    assign qfull  = (cnt_reg == 2'd2);
    assign empty  = (cnt_reg == 2'd0);
    assign rd_en  = pop && !empty;
    assign result = ent_reg[rd_ptr_reg];

    // fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd_en)
            cnt_next = cnt_reg + 2'd1;
        else if (rd_en && !wr)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        if (wr)
            ent_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// ===== design/mfm_sector_encoder_unit.sv =====
// channel  | handshake        | payload
// -------- | ---------------- | -----------------------------------------
// input    | push / full      | item   (op, track, sector, data_pair)
// result   | empty / pop      | result (cells, cells_valid, last)
//
// the back sequencer emits one result word per cycle while the result queue has
// room; a data item gives 1 word, a start 30, a finish 56; op 3 is dropped.
// input items wait in a job queue of JOB_DEPTH entries; full rises when it fills.
// a stalled result port holds the back part once the two-entry result queue fills.
// reset presets the crc to ffff and the last data bit to zero, queues empty.
// top level: depends on mfmse_pkg, mfmse_front, mfmse_back, mfmse_outq
`timescale 1ns / 1ps
`default_nettype none

module mfm_sector_encoder_unit
    import mfmse_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    logic      job_valid;
    job_t      job;
    logic      job_pop;
    logic      res_full;
    logic      res_wr;
    out_item_t res;

    // accept and classify
    mfmse_front #(
        .JOB_DEPTH (JOB_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    // sequence bytes, crc and mfm cells
    mfmse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_wr    (res_wr),
        .res       (res)
    );

    // result queue
    mfmse_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (res_wr),
        .wdata  (res),
        .qfull  (res_full),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== design/mfmse_checker.sv =====
// port-level checker for the mfm sector encoder and its bind to the top level
// depends on mfmse_pkg and mfm_sector_encoder_unit
`timescale 1ns / 1ps
`default_nettype none

module mfmse_checker
    import mfmse_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire out_item_t result
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting");

    // a word carries two cells, or one only as the final word of a finish item
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.cells_valid == 2'd2 ||
                    (result.cells_valid == 2'd1 && result.last)))
        else $error("bad cells_valid");

    // the final word of a finish item has one cell
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last) |-> (result.cells_valid == 2'd1))
        else $error("last word with two cells");

    // single-cell word has its lower cell cleared
    a_lower: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.cells_valid == 2'd1) |-> (result.cells[15:0] == 16'h0000))
        else $error("lower cell not cleared");

    // mfm never puts two one-cells side by side
    a_mfm: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.cells & (result.cells >> 1)) == 32'h0))
        else $error("adjacent one cells");

endmodule

bind mfm_sector_encoder_unit mfmse_checker u_chk (.*);

`default_nettype wire

// ===== tb/sv/mfmse_stream_check.sv =====
// result checker for the mfm sector encoder: watches both channels, predicts
// the mfm result words of every accepted item and compares them in order
// depends on mfmse_pkg for the item types, op codes and format bytes
`timescale 1ns / 1ps

module mfmse_stream_check
    import mfmse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t result,
    output int        outstanding,
    output int        fail_count
);

    // predicted encoder state
    logic [15:0] crc_state;
    logic        last_bit;

    // bytes of one item's run, with their mark flags, before mfm packing
    logic [7:0] run_bytes[$];
    bit         run_marks[$];

    // mfm words still to come from the encoder, oldest first
    out_item_t expected_words[$];

    int fail_total = 0;
    assign fail_count = fail_total;

    // crc-16-ccitt, one byte msb first
    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    // encode one byte, carrying the last data bit across calls
    function automatic logic [15:0] byte_to_cell(input logic [7:0] data, input bit mark);
        logic [15:0] cell_bits;
        logic        d;
        cell_bits = '0;
        for (int i = 7; i >= 0; i--) begin
            d         = data[i];
            cell_bits = {cell_bits[13:0], ~(last_bit | d), d};
            last_bit  = d;
        end
        // mark bytes lose the clock bit in front of data bit 2
        if (mark)
            cell_bits[5] = 1'b0;
        return cell_bits;
    endfunction

    task automatic add_byte(input logic [7:0] data, input bit mark);
        run_bytes.push_back(data);
        run_marks.push_back(mark);
    endtask

    // pack the run two cells to a word
    task automatic pack_run(input bit finish);
        int        words;
        out_item_t w;
        words = (run_bytes.size() + 1) / 2;
        for (int k = 0; k < words; k++) begin
            w.cells[31:16] = byte_to_cell(run_bytes[2*k], run_marks[2*k]);
            if (2*k + 1 < run_bytes.size()) begin
                w.cells[15:0] = byte_to_cell(run_bytes[2*k+1], run_marks[2*k+1]);
                w.cells_valid = 2'd2;
            end
            else begin
                w.cells[15:0] = 16'h0000;
                w.cells_valid = 2'd1;
            end
            w.last = finish && (k == words - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic predict_item(input in_item_t it);
        logic [7:0]  hdr[8];
        logic [15:0] hdr_crc;
        run_bytes.delete();
        run_marks.delete();
        case (it.op)
            OP_START:
            begin
                hdr = '{MARK_BYTE, MARK_BYTE, MARK_BYTE, IDAM_BYTE,
                        {1'b0, it.track[7:1]}, {7'd0, it.track[0]},
                        {4'd0, it.sector} + 8'd1, SIZE_CODE};
                repeat (12) add_byte(8'h00, 1'b0);
                hdr_crc = CRC_PRESET;
                for (int i = 0; i < 8; i++)
                begin
                    add_byte(hdr[i], i < 3);
                    hdr_crc = crc_ccitt_byte(hdr_crc, hdr[i]);
                end
                add_byte(hdr_crc[15:8], 1'b0);
                add_byte(hdr_crc[7:0], 1'b0);
                repeat (22) add_byte(GAP_BYTE, 1'b0);
                repeat (12) add_byte(8'h00, 1'b0);
                // data crc restarts and covers the data address mark
                crc_state = CRC_PRESET;
                repeat (3)
                begin
                    add_byte(MARK_BYTE, 1'b1);
                    crc_state = crc_ccitt_byte(crc_state, MARK_BYTE);
                end
                add_byte(DAM_BYTE, 1'b0);
                crc_state = crc_ccitt_byte(crc_state, DAM_BYTE);
                pack_run(1'b0);
            end
            OP_DATA:
            begin
                add_byte(it.data_pair[15:8], 1'b0);
                add_byte(it.data_pair[7:0], 1'b0);
                crc_state = crc_ccitt_byte(crc_state, it.data_pair[15:8]);
                crc_state = crc_ccitt_byte(crc_state, it.data_pair[7:0]);
                pack_run(1'b0);
            end
            OP_FINISH:
            begin
                add_byte(crc_state[15:8], 1'b0);
                add_byte(crc_state[7:0], 1'b0);
                repeat (109) add_byte(GAP_BYTE, 1'b0);
                crc_state = CRC_PRESET;
                pack_run(1'b1);
            end
            default:
            begin
                // unused op: dropped without results
            end
        endcase
    endtask

    task automatic check_word(input out_item_t got);
        out_item_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: expected no word, got cells %h valid %0d last %0d",
                     $time, got.cells, got.cells_valid, got.last);
            fail_total++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.cells !== want.cells)
            begin
                $display("%0t: cells expected %h got %h", $time, want.cells, got.cells);
                fail_total++;
            end
            if (got.cells_valid !== want.cells_valid)
            begin
                $display("%0t: cells_valid expected %0d got %0d",
                         $time, want.cells_valid, got.cells_valid);
                fail_total++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
                fail_total++;
            end
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_state = CRC_PRESET;
            last_bit  = 1'b0;
            expected_words.delete();
            outstanding <= 0;
        end
        else
        begin
            if (push && !full)
                predict_item(item);
            if (pop && !empty)
                check_word(result);
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the mfm sector encoder: clock, reset, item stimulus and
// random result stalls; depends on mfmse_pkg, mfm_sector_encoder_unit and
// mfmse_stream_check
`timescale 1ns / 1ps

module tb;
    import mfmse_pkg::*;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  item  = '0;
    logic      full;
    logic      empty;
    out_item_t result;
    int        outstanding;
    int        fail_count;
    bit        steady_flow = 1'b0;

    always #2 clk = ~clk;

    mfm_sector_encoder_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    mfmse_stream_check stream_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .empty       (empty),
        .pop         (pop),
        .result      (result),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    function automatic in_item_t make_item(input logic [1:0] op, input logic [7:0] track,
                                           input logic [3:0] sector,
                                           input logic [15:0] data_pair);
        in_item_t it;
        it.op        = op;
        it.track     = track;
        it.sector    = sector;
        it.data_pair = data_pair;
        return it;
    endfunction

    // present one item after a random gap and hold it until accepted
    task automatic send_item(input in_item_t it);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
    endtask

    // hold the input until every predicted word has come out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // start, a few data pairs, finish
    task automatic send_sector(input logic [7:0] track, input logic [3:0] sector,
                               input int pairs);
        send_item(make_item(OP_START, track, sector, 16'($urandom)));
        repeat (pairs) send_item(make_item(OP_DATA, 8'($urandom), 4'($urandom),
                                           16'($urandom)));
        send_item(make_item(OP_FINISH, 8'($urandom), 4'($urandom), 16'($urandom)));
    endtask

    // result side: random stall before each word
    initial
    begin
        int w;
        wait (rst_n === 1'b1);
        forever
        begin
            w = steady_flow ? 0 : $urandom_range(0, 3);
            if (w != 0)
            begin
                pop <= 1'b0;
                repeat (w) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    // stimulus and verdict
    initial
    begin
        int          sent;
        int          pairs;
        logic [7:0]  track;
        logic [3:0]  sector;
        in_item_t    noise;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // data and finish with no start before them
        send_item(make_item(OP_DATA, 8'h00, 4'h0, 16'h0000));
        send_item(make_item(OP_FINISH, 8'h00, 4'h0, 16'h0000));
        // lowest header, data extremes and mark-like bytes
        send_item(make_item(OP_START, 8'd0, 4'd0, 16'h0000));
        send_item(make_item(OP_DATA, 8'h00, 4'h0, 16'h0000));
        send_item(make_item(OP_DATA, 8'hFF, 4'hF, 16'hFFFF));
        send_item(make_item(OP_DATA, 8'h00, 4'h0, 16'hA1FE));
        send_item(make_item(OP_FINISH, 8'hFF, 4'hF, 16'hFFFF));
        // highest legal header
        send_item(make_item(OP_START, 8'd159, 4'd8, 16'hFFFF));
        send_item(make_item(OP_DATA, 8'd0, 4'd0, 16'h8001));
        send_item(make_item(OP_FINISH, 8'd0, 4'd0, 16'h0000));
        wait_drained();
        // out of range header, unused op in the middle of a sector
        steady_flow <= 1'b1;
        send_item(make_item(OP_START, 8'hFF, 4'hF, 16'h0000));
        send_item(make_item(OP_UNUSED, 8'hFF, 4'hF, 16'hFFFF));
        send_item(make_item(OP_DATA, 8'h00, 4'h0, 16'h5AA5));
        send_item(make_item(OP_FINISH, 8'h00, 4'h0, 16'h0000));
        // start right after start
        steady_flow <= 1'b0;
        send_item(make_item(OP_START, 8'd160, 4'd9, 16'h0000));
        send_item(make_item(OP_START, 8'd1, 4'd1, 16'h0000));
        send_item(make_item(OP_DATA, 8'h00, 4'h0, 16'h7FFE));
        send_item(make_item(OP_FINISH, 8'h00, 4'h0, 16'h0000));
        send_item(make_item(OP_UNUSED, 8'h00, 4'h0, 16'h0000));
        wait_drained();

        // random part: mostly whole sectors, some loose items
        while (sent < 110)
        begin
            steady_flow <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                pairs = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
                if ($urandom_range(0, 4) == 0)
                begin
                    track  = 8'($urandom_range(0, 255));
                    sector = 4'($urandom_range(0, 15));
                end
                else
                begin
                    track  = 8'($urandom_range(0, 159));
                    sector = 4'($urandom_range(0, 8));
                end
                send_sector(track, sector, pairs);
                sent += pairs + 2;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    noise = make_item(2'($urandom_range(0, 3)), 8'($urandom),
                                      4'($urandom), 16'($urandom));
                    send_item(noise);
                    if (noise.op != OP_UNUSED)
                        sent++;
                end
            end
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // let the last words out, then watch for strays
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hang guard
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
